/* hw/rtl/iida_pkg.sv */
`timescale 1ns / 1ps
package iida_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W    = 5;
	localparam int VAL_W    = 32;
	localparam int CNTF_W   = 5;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int S_DATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((VAL_W + CNTF_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_UP,
		CELL_DOWN
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
	} cell_ctrl_t;

	function automatic logic [DATA_WIDTH-1:0] to_data(input logic [VAL_W-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] t;
		t = 64'(d);
		return t[VAL_W-1:0];
	endfunction

endpackage

/* hw/rtl/indexed_insert_delete_array.sv */
`timescale 1ns / 1ps
// an accepted request beat's result beat is registered and appears in the next cycle
// throughput: one request per cycle while the result beats are taken;
// the shifting cells of the row update in the same cycle as the output register
// reset: entry count and output valid clear at once; stored words stay
// undefined until written
module indexed_insert_delete_array (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [iida_pkg::S_DATA_W-1:0] s_tdata,  // index, value, zero fill
	input  logic [iida_pkg::OP_W-1:0]     s_tuser,  // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [iida_pkg::M_DATA_W-1:0] m_tdata,  // read_value, entry_count, zero fill
	output logic [iida_pkg::STAT_W-1:0]   m_tuser   // status
);

	localparam int CAP = iida_pkg::CAPACITY;
	localparam int DW  = iida_pkg::DATA_WIDTH;
	localparam int CW  = iida_pkg::CMP_W;

	logic [iida_pkg::CNT_W-1:0]  count_q;
	logic                        m_valid_q;
	logic [iida_pkg::VAL_W-1:0]  rd_val_q;
	logic [iida_pkg::CNTF_W-1:0] cnt_out_q;
	iida_pkg::status_t           status_q;

	logic [DW-1:0]          entries [CAP];
	iida_pkg::cell_ctrl_t   ctrl    [CAP];

	iida_pkg::op_t               op;
	logic [iida_pkg::IDX_W-1:0]  index;
	logic [DW-1:0]               word;
	logic                        accept;
	logic [CW-1:0]               idx_ext;
	logic [CW-1:0]               cnt_ext;
	logic [CW-1:0]               ins_at;
	logic [CW-1:0]               del_at;
	logic                        full;
	logic                        empty;
	logic                        ins_ok;
	logic                        del_ok;
	logic                        rd_ok;
	logic [CW-1:0]               sel;
	logic [DW-1:0]               sel_word;
	logic [iida_pkg::CNT_W-1:0]  count_d;
	logic [iida_pkg::VAL_W-1:0]  rd_val_d;
	iida_pkg::status_t           status_d;

	assign op     = iida_pkg::op_t'(s_tuser);
	assign index  = s_tdata[iida_pkg::IDX_W-1:0];
	assign word   = iida_pkg::to_data(s_tdata[iida_pkg::IDX_W +: iida_pkg::VAL_W]);
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign idx_ext = CW'(index);
	assign cnt_ext = CW'(count_q);
	assign full    = (cnt_ext == CW'(CAP));
	assign empty   = (count_q == '0);
	assign ins_at  = (idx_ext >= cnt_ext) ? cnt_ext : idx_ext;
	assign del_at  = (idx_ext >= cnt_ext) ? (cnt_ext - CW'(1)) : idx_ext;
	assign ins_ok  = accept && (op == iida_pkg::OP_INSERT) && !full;
	assign del_ok  = accept && (op == iida_pkg::OP_DELETE) && !empty;
	assign rd_ok   = (op == iida_pkg::OP_READ) && (idx_ext < cnt_ext);
	assign sel     = (op == iida_pkg::OP_DELETE) ? del_at : idx_ext;
	assign sel_word = entries[sel[iida_pkg::ADDR_W-1:0]];

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [DW-1:0] lower;
		logic [DW-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = entries[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = entries[i+1];
		end

		always_comb begin
			ctrl[i].cmd = iida_pkg::CELL_HOLD;
			if (ins_ok) begin
				if (CW'(i) == ins_at) begin
					ctrl[i].cmd = iida_pkg::CELL_LOAD;
				end else if (CW'(i) > ins_at && CW'(i) <= cnt_ext) begin
					ctrl[i].cmd = iida_pkg::CELL_UP;
				end
			end else if (del_ok) begin
				if (CW'(i) >= del_at && (CW'(i) + CW'(1)) < cnt_ext) begin
					ctrl[i].cmd = iida_pkg::CELL_DOWN;
				end
			end
		end

		iida_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl[i]),
			.word  (word),
			.lower (lower),
			.upper (upper),
			.entry (entries[i])
		);
	end

	always_comb begin
		count_d  = count_q;
		rd_val_d = '0;
		status_d = iida_pkg::ST_OK;
		case (op)
			iida_pkg::OP_INSERT: begin
				if (full) begin
					status_d = iida_pkg::ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			iida_pkg::OP_DELETE: begin
				if (empty) begin
					status_d = iida_pkg::ST_EMPTY;
				end else begin
					count_d  = count_q - 1'b1;
					rd_val_d = iida_pkg::to_field(sel_word);
				end
			end
			iida_pkg::OP_READ: begin
				if (rd_ok) begin
					rd_val_d = iida_pkg::to_field(sel_word);
				end else begin
					status_d = iida_pkg::ST_RANGE;
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_val_q  <= rd_val_d;
			cnt_out_q <= iida_pkg::CNTF_W'(count_d);
			status_q  <= status_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = iida_pkg::M_DATA_W'({cnt_out_q, rd_val_q});
	assign m_tuser  = status_q;

endmodule

/* hw/rtl/iida_cell.sv */
`timescale 1ns / 1ps
module iida_cell (
	input  logic                              clk,
	input  iida_pkg::cell_ctrl_t              ctrl,
	input  logic [iida_pkg::DATA_WIDTH-1:0]   word,
	input  logic [iida_pkg::DATA_WIDTH-1:0]   lower,
	input  logic [iida_pkg::DATA_WIDTH-1:0]   upper,
	output logic [iida_pkg::DATA_WIDTH-1:0]   entry
);

	logic [iida_pkg::DATA_WIDTH-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			iida_pkg::CELL_LOAD: entry_q <= word;
			iida_pkg::CELL_UP:   entry_q <= lower;
			iida_pkg::CELL_DOWN: entry_q <= upper;
			default:             entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;

endmodule

/* hw/rtl/iida_checker.sv */
`timescale 1ns / 1ps
module iida_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [iida_pkg::M_DATA_W-1:0] m_tdata,
	input logic [iida_pkg::STAT_W-1:0]   m_tuser
);

	localparam int VW = iida_pkg::VAL_W;
	localparam int FW = iida_pkg::CNTF_W;

	logic [VW-1:0] rd_val;
	logic [FW-1:0] cnt;

	assign rd_val = m_tdata[VW-1:0];
	assign cnt    = m_tdata[VW +: FW];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != iida_pkg::ST_OK |-> rd_val == '0)
		else $error("error result carries nonzero word");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == iida_pkg::ST_FULL |-> cnt == FW'(iida_pkg::CAPACITY))
		else $error("full reported below capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == iida_pkg::ST_EMPTY |-> cnt == '0)
		else $error("empty reported with entries held");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no pending result");

endmodule

bind indexed_insert_delete_array iida_checker u_iida_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
